// File: src/sffm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffm_pkg
// Types and constants shared by the servo frame failsafe monitor.
// ----------------------------------------------------------------------------
package sffm_pkg;

	localparam int NUM_CH  = 8;
	localparam int WORD_W  = 16;
	localparam int WIDTH_W = 15;
	localparam int COUNT_W = 8;
	localparam int CHAN_W  = 4;
	localparam int VALID_BIT = 15;
	localparam int FRAME_CHS = 4;

	typedef logic [WORD_W-1:0]  word_t;
	typedef logic [WIDTH_W-1:0] width_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [CHAN_W-1:0]  chan_t;

	localparam logic CMD_FRAME = 1'b0;
	localparam logic CMD_TICK  = 1'b1;
	localparam logic FILTER_USED = 1'b0;

	localparam word_t ID_CH_LOW  = 16'd1;
	localparam word_t ID_CH_HIGH = 16'd2;

	localparam count_t COUNT_MAX = 8'd255;
	localparam count_t COUNT_ON  = 8'd2;

	// apb register map, word index
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_CHANNEL = 2'd0;
	localparam logic [1:0] REG_MIN     = 2'd1;
	localparam logic [1:0] REG_MAX     = 2'd2;

	localparam chan_t  CHANNEL_RST = 4'd3;
	localparam width_t MIN_RST     = 15'd1500;
	localparam width_t MAX_RST     = 15'd4500;

	typedef struct packed {
		logic  cmd;
		word_t frame_id;
		logic  filter_hit;
		word_t word_a;
		word_t word_b;
		word_t word_c;
		word_t word_d;
	} item_t;

	// outcome of the failsafe channel compare on a commit
	typedef struct packed {
		logic hit;
		logic good;
	} check_t;

endpackage

// File: src/sffm_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffm_item_if
// Input channel: a received servo frame or a period tick.
// ----------------------------------------------------------------------------
interface sffm_item_if;
	logic            valid;
	logic            ready;
	logic            cmd;
	sffm_pkg::word_t frame_id;
	logic            filter_hit;
	sffm_pkg::word_t word_a;
	sffm_pkg::word_t word_b;
	sffm_pkg::word_t word_c;
	sffm_pkg::word_t word_d;

	modport source (output valid, cmd, frame_id, filter_hit, word_a, word_b, word_c,
		word_d, input ready);
	modport sink (input valid, cmd, frame_id, filter_hit, word_a, word_b, word_c,
		word_d, output ready);
endinterface

// File: src/sffm_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffm_result_if
// Result channel: radio state, held pulse widths and good-pulse count.
// ----------------------------------------------------------------------------
interface sffm_result_if;
	logic             valid;
	logic             ready;
	logic             link_up;
	sffm_pkg::width_t pulse_1;
	sffm_pkg::width_t pulse_2;
	sffm_pkg::width_t pulse_3;
	sffm_pkg::width_t pulse_4;
	sffm_pkg::width_t pulse_5;
	sffm_pkg::width_t pulse_6;
	sffm_pkg::width_t pulse_7;
	sffm_pkg::width_t pulse_8;
	sffm_pkg::count_t good_pulse_count;

	modport source (output valid, link_up, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
		pulse_6, pulse_7, pulse_8, good_pulse_count, input ready);
	modport sink (input valid, link_up, pulse_1, pulse_2, pulse_3, pulse_4, pulse_5,
		pulse_6, pulse_7, pulse_8, good_pulse_count, output ready);
endinterface

// File: src/sffm_frame_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffm_frame_unit
// Stages frame words, works out which channels load and checks the failsafe
// channel's width against the window.
// ----------------------------------------------------------------------------
module sffm_frame_unit (
	input  sffm_pkg::item_t                          item,
	input  sffm_pkg::word_t  [sffm_pkg::NUM_CH-1:0] staged,
	input  sffm_pkg::chan_t                          fs_channel,
	input  sffm_pkg::width_t                         fs_min,
	input  sffm_pkg::width_t                         fs_max,
	output sffm_pkg::word_t  [sffm_pkg::NUM_CH-1:0] staged_next,
	output logic             [sffm_pkg::NUM_CH-1:0] load,
	output sffm_pkg::check_t                         check
);

	logic             frame_ok;
	logic             is_low;
	logic             is_high;
	sffm_pkg::width_t fs_width;
	sffm_pkg::word_t  [sffm_pkg::FRAME_CHS-1:0] words;

	assign words = {item.word_d, item.word_c, item.word_b, item.word_a};

	assign is_low   = (item.frame_id == sffm_pkg::ID_CH_LOW);
	assign is_high  = (item.frame_id == sffm_pkg::ID_CH_HIGH);
	assign frame_ok = (item.cmd == sffm_pkg::CMD_FRAME) &&
		(item.filter_hit == sffm_pkg::FILTER_USED) && (is_low || is_high);

	always_comb begin
		staged_next = staged;
		for (int i = 0; i < sffm_pkg::FRAME_CHS; i++) begin
			if (frame_ok && is_low) begin
				staged_next[i] = words[i];
			end
			if (frame_ok && is_high) begin
				staged_next[i + sffm_pkg::FRAME_CHS] = words[i];
			end
		end
	end

	// frame 2 commits every staged word that carries its valid flag
	always_comb begin
		check.hit = 1'b0;
		fs_width  = '0;
		for (int i = 0; i < sffm_pkg::NUM_CH; i++) begin
			load[i] = frame_ok && is_high && staged_next[i][sffm_pkg::VALID_BIT];
			if (load[i] && (fs_channel == sffm_pkg::CHAN_W'(i + 1))) begin
				check.hit = 1'b1;
				fs_width  = staged_next[i][sffm_pkg::WIDTH_W-1:0];
			end
		end
		check.good = (fs_width > fs_min) && (fs_width < fs_max);
	end

endmodule

// File: src/servo_frame_failsafe_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_frame_failsafe_monitor
// Holds eight servo pulse widths from received frames and judges radio link
// presence from the failsafe channel and a periodic tick.
// ----------------------------------------------------------------------------
// usage
// item channel takes a servo frame (cmd 0) or a 25 ms tick (cmd 1); only
// filter 0 frames with id 1 (channels 1-4) or id 2 (channels 5-8) count,
// and id 2 commits every staged word that carries its valid flag
// result channel returns one word per item: link_up, the eight held pulse
// widths and the good-pulse count, all taken after that item's update
// an accepted item waits in the input register, then passes through the
// update logic into the state registers, which drive the result word directly
// throughput is one item per cycle while the result is not stalled, set by
// the single update stage
// when the result is stalled the state cannot move, the input register holds
// one more word and ready drops only once both are full
// reset clears staged words, widths, count, tick phase and link_up, and sets
// the failsafe registers to channel 3, window (1500, 4500)
// apb registers: 0x0 failsafe channel, 0x4 window min, 0x8 window max
// ----------------------------------------------------------------------------
module servo_frame_failsafe_monitor #(
	parameter int TICKS_PER_CHECK = 2
) (
	input  logic                           clk,
	input  logic                           arst_n,
	sffm_item_if.sink                      item,
	sffm_result_if.source                  result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sffm_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	localparam int PH_W = (TICKS_PER_CHECK > 1) ? $clog2(TICKS_PER_CHECK) : 1;

	sffm_pkg::chan_t  fs_channel_q;
	sffm_pkg::width_t fs_min_q;
	sffm_pkg::width_t fs_max_q;

	sffm_pkg::item_t  item_s1;
	logic             valid_s1;
	logic             out_valid_q;
	logic             adv;
	logic             fire;

	sffm_pkg::word_t  [sffm_pkg::NUM_CH-1:0] staged_q;
	sffm_pkg::word_t  [sffm_pkg::NUM_CH-1:0] staged_next;
	sffm_pkg::width_t [sffm_pkg::NUM_CH-1:0] pulse_q;
	logic             [sffm_pkg::NUM_CH-1:0] load;
	sffm_pkg::check_t check;
	sffm_pkg::count_t count_q;
	logic             radio_q;
	logic [PH_W-1:0]  phase_q;
	logic [PH_W:0]    phase_sum;
	logic             cfg_wr;

	// apb
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_channel_q <= sffm_pkg::CHANNEL_RST;
			fs_min_q     <= sffm_pkg::MIN_RST;
			fs_max_q     <= sffm_pkg::MAX_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				sffm_pkg::REG_CHANNEL: fs_channel_q <= pwdata[sffm_pkg::CHAN_W-1:0];
				sffm_pkg::REG_MIN:     fs_min_q     <= pwdata[sffm_pkg::WIDTH_W-1:0];
				sffm_pkg::REG_MAX:     fs_max_q     <= pwdata[sffm_pkg::WIDTH_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sffm_pkg::REG_CHANNEL: prdata = 32'(fs_channel_q);
			sffm_pkg::REG_MIN:     prdata = 32'(fs_min_q);
			sffm_pkg::REG_MAX:     prdata = 32'(fs_max_q);
			default:               prdata = '0;
		endcase
	end

	// handshake
	assign adv        = !out_valid_q || result.ready;
	assign item.ready = !valid_s1 || adv;
	assign fire       = valid_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (item.ready) begin
				valid_s1 <= item.valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{cmd: item.cmd, frame_id: item.frame_id, filter_hit: item.filter_hit,
				word_a: item.word_a, word_b: item.word_b, word_c: item.word_c,
				word_d: item.word_d};
		end
	end

	sffm_frame_unit u_frame (
		.item        (item_s1),
		.staged      (staged_q),
		.fs_channel  (fs_channel_q),
		.fs_min      (fs_min_q),
		.fs_max      (fs_max_q),
		.staged_next (staged_next),
		.load        (load),
		.check       (check)
	);

	assign phase_sum = {1'b0, phase_q} + (PH_W + 1)'(1);

	// state registers double as the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staged_q <= '0;
			pulse_q  <= '0;
			count_q  <= '0;
			radio_q  <= 1'b0;
			phase_q  <= '0;
		end else if (fire) begin
			staged_q <= staged_next;
			for (int i = 0; i < sffm_pkg::NUM_CH; i++) begin
				if (load[i]) begin
					pulse_q[i] <= staged_next[i][sffm_pkg::WIDTH_W-1:0];
				end
			end
			if (item_s1.cmd == sffm_pkg::CMD_TICK) begin
				if (phase_sum >= (PH_W + 1)'(TICKS_PER_CHECK)) begin
					// a count of exactly one leaves the radio as it was
					if (count_q == '0) begin
						radio_q <= 1'b0;
					end else if (count_q >= sffm_pkg::COUNT_ON) begin
						radio_q <= 1'b1;
					end
					count_q <= '0;
					phase_q <= '0;
				end else begin
					phase_q <= phase_sum[PH_W-1:0];
				end
			end else if (check.hit) begin
				if (check.good) begin
					if (count_q != sffm_pkg::COUNT_MAX) begin
						count_q <= count_q + sffm_pkg::COUNT_W'(1);
					end
				end else begin
					count_q <= '0;
					radio_q <= 1'b0;
				end
			end
		end
	end

	assign result.valid            = out_valid_q;
	assign result.link_up          = radio_q;
	assign result.pulse_1          = pulse_q[0];
	assign result.pulse_2          = pulse_q[1];
	assign result.pulse_3          = pulse_q[2];
	assign result.pulse_4          = pulse_q[3];
	assign result.pulse_5          = pulse_q[4];
	assign result.pulse_6          = pulse_q[5];
	assign result.pulse_7          = pulse_q[6];
	assign result.pulse_8          = pulse_q[7];
	assign result.good_pulse_count = count_q;

endmodule

// File: src/sffm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sffm_checker
// Port-level checks on the servo frame failsafe monitor, bound to the top.
// ----------------------------------------------------------------------------
module sffm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        item_valid,
	input logic                        item_ready,
	input logic                        result_valid,
	input logic                        result_ready,
	input logic                        link_up,
	input sffm_pkg::width_t            pulse_1,
	input sffm_pkg::count_t            good_pulse_count,
	input logic                        psel,
	input logic [sffm_pkg::ADDR_W-1:0] paddr,
	input logic [31:0]                 prdata,
	input logic                        pready
);

	// a stalled word keeps its contents
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(link_up) &&
		$stable(pulse_1) && $stable(good_pulse_count))
		else $error("result word changed while stalled");

	// input side only backs up once a result is waiting
	a_ready_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> result_valid)
		else $error("item ready low with no result pending");

	a_ready_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready && result_ready |=> item_ready)
		else $error("item ready stayed low after result taken");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

	a_unmapped_read: assert property (@(posedge clk) disable iff (!arst_n)
		psel && (paddr[3:2] == 2'd3) |-> prdata == '0)
		else $error("unmapped register read not zero");

endmodule

bind servo_frame_failsafe_monitor sffm_checker u_sffm_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.item_valid       (item.valid),
	.item_ready       (item.ready),
	.result_valid     (result.valid),
	.result_ready     (result.ready),
	.link_up          (result.link_up),
	.pulse_1          (result.pulse_1),
	.good_pulse_count (result.good_pulse_count),
	.psel             (psel),
	.paddr            (paddr),
	.prdata           (prdata),
	.pready           (pready)
);

// File: verif/tb_servo_frame_failsafe_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_servo_frame_failsafe_monitor
// Drives servo frames and period ticks through the item channel and checks
// each result word against a cycle-free model of the staging, commit and
// failsafe logic. A directed table comes first, then random traffic over a
// series of failsafe channel and window settings written through apb.
// ----------------------------------------------------------------------------
module tb_servo_frame_failsafe_monitor;
	import sffm_pkg::*;

	localparam int TICKS       = 2;
	localparam int IDLE_LIMIT  = 2000;
	localparam int DRAIN_PAD   = 8;
	localparam int PHASE_ITEMS = 140;
	localparam int NUM_PHASES  = 10;
	localparam int NUM_DIR     = 24;

	localparam logic  FILTER_OTHER = ~FILTER_USED;
	localparam word_t VALID_FLAG   = word_t'(1) << VALID_BIT;

	typedef struct packed {
		logic                  radio;
		width_t [1:NUM_CH]     pulse;
		count_t                count;
	} status_t;

	typedef struct packed {
		item_t   it;
		logic    typed;
		status_t want;
	} dir_row_t;

	localparam status_t NO_PULSES    = '0;
	localparam status_t FIRST_COMMIT = '{1'b0,
		'{15'd0, 15'd32767, 15'd1501, 15'd0, 15'd100, 15'd0, 15'd0, 15'd32767}, 8'd1};

	// window is the reset one, (1500, 4500) on channel 3
	localparam dir_row_t DIRECTED [NUM_DIR] = '{
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b1, NO_PULSES},
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b1, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_USED,  16'h8000, 16'hffff, 16'h85dd, 16'h7fff},
			1'b1, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_OTHER, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b1, NO_PULSES},
		'{'{CMD_FRAME, 16'hffff,   FILTER_USED,  16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b1, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h8064, 16'h0000, 16'h7fff, 16'hffff},
			1'b1, FIRST_COMMIT},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h8064, 16'h0000, 16'h7fff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  ID_CH_HIGH, FILTER_USED,  16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  16'hffff,   FILTER_OTHER, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_USED,  16'h0000, 16'h0000, 16'h9193, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_OTHER, 16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_USED,  16'h0000, 16'h0000, 16'h85dc, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_USED,  16'h0000, 16'h0000, 16'h9194, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h8000, 16'h8001, 16'h8002, 16'h8003},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_LOW,  FILTER_USED,  16'hffff, 16'hffff, 16'h7fff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, ID_CH_HIGH, FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, 16'h0000,   FILTER_USED,  16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_FRAME, 16'h0003,   FILTER_USED,  16'hffff, 16'hffff, 16'hffff, 16'hffff},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES},
		'{'{CMD_TICK,  16'h0000,   FILTER_USED,  16'h0000, 16'h0000, 16'h0000, 16'h0000},
			1'b0, NO_PULSES}
	};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sffm_item_if   item_bus ();
	sffm_result_if res_bus ();

	servo_frame_failsafe_monitor #(
		.TICKS_PER_CHECK(TICKS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_bus),
		.result  (res_bus),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model state and register copies
	word_t  staged [NUM_CH];
	width_t held [NUM_CH];
	count_t good_cnt;
	int     tick_ph;
	logic   radio;
	chan_t  fs_chan;
	width_t win_lo;
	width_t win_hi;

	status_t pending_status [$];
	int      mismatches;
	int      idle_cycles;
	int      hold_req;
	bit      send_calm;
	bit      recv_calm;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// applies one accepted word to the model and returns the status that follows
	function automatic status_t advance_monitor(item_t it);
		status_t r;
		int base;
		if (it.cmd == CMD_TICK) begin
			tick_ph++;
			if (tick_ph >= TICKS) begin
				if (good_cnt == '0)
					radio = 1'b0;
				else if (good_cnt >= COUNT_ON)
					radio = 1'b1;
				tick_ph = 0;
				good_cnt = '0;
			end
		end else if (it.filter_hit == FILTER_USED &&
				(it.frame_id == ID_CH_LOW || it.frame_id == ID_CH_HIGH)) begin
			base = (it.frame_id == ID_CH_LOW) ? 0 : FRAME_CHS;
			staged[base]     = it.word_a;
			staged[base + 1] = it.word_b;
			staged[base + 2] = it.word_c;
			staged[base + 3] = it.word_d;
			if (it.frame_id == ID_CH_HIGH) begin
				for (int i = 0; i < NUM_CH; i++) begin
					if (staged[i][VALID_BIT]) begin
						held[i] = staged[i][WIDTH_W-1:0];
						if (int'(fs_chan) == i + 1) begin
							if (held[i] > win_lo && held[i] < win_hi) begin
								if (good_cnt != COUNT_MAX)
									good_cnt++;
							end else begin
								good_cnt = '0;
								radio = 1'b0;
							end
						end
					end
				end
			end
		end
		r.radio = radio;
		for (int i = 0; i < NUM_CH; i++)
			r.pulse[i + 1] = held[i];
		r.count = good_cnt;
		return r;
	endfunction

	// widths biased onto the window edges
	function automatic word_t rand_word();
		width_t w;
		case ($urandom_range(0, 6))
			0: w = win_lo;
			1: w = win_lo + 1'b1;
			2: w = win_hi - 1'b1;
			3: w = win_hi;
			4: w = '0;
			5: w = '1;
			default: w = width_t'($urandom_range(0, 32767));
		endcase
		return {($urandom_range(0, 7) != 0), w};
	endfunction

	function automatic item_t rand_frame(word_t id, logic filt);
		return '{CMD_FRAME, id, filt, rand_word(), rand_word(), rand_word(), rand_word()};
	endfunction

	task automatic send_item(item_t it, logic typed, status_t want);
		int gap;
		status_t predicted;
		if ($urandom_range(0, 39) == 0)
			send_calm = !send_calm;
		gap = send_calm ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			item_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_bus.valid      <= 1'b1;
		item_bus.cmd        <= it.cmd;
		item_bus.frame_id   <= it.frame_id;
		item_bus.filter_hit <= it.filter_hit;
		item_bus.word_a     <= it.word_a;
		item_bus.word_b     <= it.word_b;
		item_bus.word_c     <= it.word_c;
		item_bus.word_d     <= it.word_d;
		do @(posedge clk); while (!item_bus.ready);
		predicted = advance_monitor(it);
		pending_status.push_back(typed ? want : predicted);
	endtask

	task automatic send_random(int budget);
		int sent;
		sent = 0;
		while (sent < budget) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					send_item(rand_frame(ID_CH_LOW, FILTER_USED), 1'b0, NO_PULSES);
					send_item(rand_frame(ID_CH_HIGH, FILTER_USED), 1'b0, NO_PULSES);
					sent += 2;
				end
				8, 9, 10, 11, 18, 19: begin
					send_item('{CMD_TICK, word_t'($urandom), logic'($urandom),
						word_t'($urandom), word_t'($urandom), word_t'($urandom),
						word_t'($urandom)}, 1'b0, NO_PULSES);
					sent++;
				end
				12, 13: begin
					send_item(rand_frame(ID_CH_HIGH, FILTER_USED), 1'b0, NO_PULSES);
					sent++;
				end
				14: begin
					send_item(rand_frame(ID_CH_LOW, FILTER_USED), 1'b0, NO_PULSES);
					sent++;
				end
				default: begin
					// noise: any id, either filter, raw words
					send_item('{CMD_FRAME, word_t'($urandom), logic'($urandom),
						word_t'($urandom), word_t'($urandom), word_t'($urandom),
						word_t'($urandom)}, 1'b0, NO_PULSES);
					sent++;
				end
			endcase
		end
	endtask

	task automatic drain();
		item_bus.valid <= 1'b0;
		while (pending_status.size() != 0) @(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		// return to idle before the next setup
		@(posedge clk);
		case (idx)
			REG_CHANNEL: fs_chan = value[CHAN_W-1:0];
			REG_MIN:     win_lo  = value[WIDTH_W-1:0];
			REG_MAX:     win_hi  = value[WIDTH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_window(chan_t ch, width_t lo, width_t hi);
		apb_write(REG_CHANNEL, 32'(ch));
		apb_write(REG_MIN, 32'(lo));
		apb_write(REG_MAX, 32'(hi));
	endtask

	// result checker
	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (arst_n && res_bus.valid && res_bus.ready) begin
			got = '{res_bus.link_up, '{res_bus.pulse_1, res_bus.pulse_2, res_bus.pulse_3,
				res_bus.pulse_4, res_bus.pulse_5, res_bus.pulse_6, res_bus.pulse_7,
				res_bus.pulse_8}, res_bus.good_pulse_count};
			if (pending_status.size() == 0) begin
				$error("result word with nothing expected");
				mismatches++;
			end else begin
				want = pending_status.pop_front();
				if (got.radio !== want.radio) begin
					$error("link_up expected %0d got %0d", want.radio, got.radio);
					mismatches++;
				end
				for (int i = 1; i <= NUM_CH; i++) begin
					if (got.pulse[i] !== want.pulse[i]) begin
						$error("pulse_%0d expected %0d got %0d", i, want.pulse[i],
							got.pulse[i]);
						mismatches++;
					end
				end
				if (got.count !== want.count) begin
					$error("good_pulse_count expected %0d got %0d", want.count, got.count);
					mismatches++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_bus.valid && item_bus.ready) || (res_bus.valid && res_bus.ready) || psel)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// result side back-pressure
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req != 0) begin
				stall = hold_req;
				hold_req = 0;
			end else begin
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				stall = recv_calm ? 0 : $urandom_range(0, 6);
			end
			if (stall != 0) begin
				res_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_bus.ready <= 1'b1;
			do @(posedge clk); while (!res_bus.valid);
		end
	end

	initial begin
		clk                 = 1'b0;
		arst_n              = 1'b0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		item_bus.valid      = 1'b0;
		item_bus.cmd        = CMD_FRAME;
		item_bus.frame_id   = '0;
		item_bus.filter_hit = FILTER_USED;
		item_bus.word_a     = '0;
		item_bus.word_b     = '0;
		item_bus.word_c     = '0;
		item_bus.word_d     = '0;
		res_bus.ready       = 1'b0;
		mismatches          = 0;
		idle_cycles         = 0;
		hold_req            = 0;
		send_calm           = 1'b0;
		recv_calm           = 1'b0;
		for (int i = 0; i < NUM_CH; i++) begin
			staged[i] = '0;
			held[i]   = '0;
		end
		good_cnt = '0;
		tick_ph  = 0;
		radio    = 1'b0;
		fs_chan  = CHANNEL_RST;
		win_lo   = MIN_RST;
		win_hi   = MAX_RST;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < NUM_DIR; r++)
			send_item(DIRECTED[r].it, DIRECTED[r].typed, DIRECTED[r].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			case (ph)
				0: set_window(CHANNEL_RST, MIN_RST, MAX_RST);
				1: set_window(chan_t'(1), '0, '1);
				2: set_window(chan_t'(8), '1, '0);
				3: set_window(chan_t'(5), width_t'(100), width_t'(101));
				4: set_window(chan_t'(0), MIN_RST, MAX_RST);
				5: set_window(chan_t'($urandom_range(9, 15)), width_t'(1000), width_t'(1002));
				6: set_window(chan_t'(15), width_t'(1000), width_t'(1002));
				7: set_window(chan_t'(4), width_t'(1000), width_t'(1002));
				default: set_window(chan_t'($urandom_range(0, 15)),
					width_t'($urandom_range(0, 32767)), width_t'($urandom_range(0, 32767)));
			endcase
			if (ph == 1) begin
				// run the count into saturation: channel 1 stays good across many commits
				send_item('{CMD_FRAME, ID_CH_LOW, FILTER_USED, VALID_FLAG | word_t'(5),
					rand_word(), rand_word(), rand_word()}, 1'b0, NO_PULSES);
				repeat (270)
					send_item(rand_frame(ID_CH_HIGH, FILTER_USED), 1'b0, NO_PULSES);
			end
			if (ph == 2)
				hold_req = 80;
			send_random(PHASE_ITEMS);
		end

		drain();
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: servo_frame_failsafe_monitor.f
src/sffm_pkg.sv
src/sffm_item_if.sv
src/sffm_result_if.sv
src/sffm_frame_unit.sv
src/servo_frame_failsafe_monitor.sv
src/sffm_checker.sv
verif/tb_servo_frame_failsafe_monitor.sv
